// ----- hw/rtl/pctd_pkg.sv -----
`default_nettype none

package pctd_pkg;

    // field widths of one input word and one output word
    localparam int SYM_W  = 8;
    localparam int CODE_W = 16;
    localparam int LEN_W  = 5;

    // default sizing
    localparam int NODES_DEF   = 512;
    localparam int MAX_LEN_DEF = 16;

    // symbol of a freshly created node (ASCII '0')
    localparam logic [SYM_W-1:0] INIT_SYMBOL = 8'd48;

    // operation select carried in tuser
    localparam logic FN_INSERT = 1'b0;
    localparam logic FN_DECODE = 1'b1;

    // result status
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    typedef struct packed {
        logic              func;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_len;
        logic              bit_req;
    } t_item;

    typedef struct packed {
        logic [SYM_W-1:0] decoded_symbol;
        logic             status;
    } t_res;

endpackage

`default_nettype wire

// ----- hw/rtl/pctd_mem.sv -----
`default_nettype none

module pctd_mem
    import pctd_pkg::*;
#(
    parameter int NODES = NODES_DEF,
    localparam int AW = $clog2(NODES),
    localparam int CW = $clog2(NODES + 1),
    localparam int RW = SYM_W + 2 * AW
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [CW-1:0] i_used,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [RW-1:0] o_rd_row,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [RW-1:0] i_wr_row
);

    // node rows: {symbol, right link, left link}
    logic [RW-1:0] r_mem [NODES];
    logic [RW-1:0] r_q;
    logic          r_q_ok;
    logic          r_root_ok;

    localparam logic [RW-1:0] RESET_ROW = {INIT_SYMBOL, {(2 * AW){1'b0}}};

    // row port: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_row;
        end
        if (i_rd_en) begin
            r_q    <= r_mem[i_rd_addr];
            // rows past the fill count, and the root until first written,
            // read as the reset row
            r_q_ok <= (i_rd_addr == '0) ? r_root_ok : (CW'(i_rd_addr) < i_used);
        end
    end

    // root row becomes valid on its first write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_ok <= 1'b0;
        end else if (i_wr_en && i_wr_addr == '0) begin
            r_root_ok <= 1'b1;
        end
    end

    assign o_rd_row = r_q_ok ? r_q : RESET_ROW;

endmodule

`default_nettype wire

// ----- hw/rtl/pctd_seq.sv -----
`default_nettype none

module pctd_seq
    import pctd_pkg::*;
#(
    parameter int NODES   = NODES_DEF,
    parameter int MAX_LEN = MAX_LEN_DEF,
    localparam int AW = $clog2(NODES),
    localparam int CW = $clog2(NODES + 1),
    localparam int LW = $clog2(MAX_LEN + 1),
    localparam int RW = SYM_W + 2 * AW
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // input word
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire t_item         i_item,
    // result
    output logic               o_res_valid,
    input  wire logic          i_res_ready,
    output t_res               o_res,
    // node table
    output logic      [CW-1:0] o_used,
    output logic               o_rd_en,
    output logic      [AW-1:0] o_rd_addr,
    input  wire logic [RW-1:0] i_rd_row,
    output logic               o_wr_en,
    output logic      [AW-1:0] o_wr_addr,
    output logic      [RW-1:0] o_wr_row
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_INS_RD   = 4'd1;
    localparam logic [3:0] S_INS_CHK  = 4'd2;
    localparam logic [3:0] S_INS_NEW  = 4'd3;
    localparam logic [3:0] S_SYM_RD   = 4'd4;
    localparam logic [3:0] S_SYM_WR   = 4'd5;
    localparam logic [3:0] S_DEC_RD   = 4'd6;
    localparam logic [3:0] S_DEC_CHK  = 4'd7;
    localparam logic [3:0] S_KID_RD   = 4'd8;
    localparam logic [3:0] S_DEC_LEAF = 4'd9;
    localparam logic [3:0] S_OUT      = 4'd10;

    logic [3:0]        r_state, n_state;
    logic [CW-1:0]     r_used, n_used;
    logic [AW-1:0]     r_walk, n_walk;
    logic [AW-1:0]     r_cur, n_cur;
    logic [LW-1:0]     r_n, n_n;
    logic [SYM_W-1:0]  r_sym, n_sym;
    logic [CODE_W-1:0] r_code, n_code;
    logic              r_bit, n_bit;
    t_res              r_res, n_res;

    // fields of the row just read
    logic [AW-1:0]    w_left, w_right, w_link, w_child;
    logic [SYM_W-1:0] w_rsym;
    logic             w_leaf;
    logic [31:0]      w_code_ext;
    logic [4:0]       w_pos;
    logic             w_cbit;
    logic [LW-1:0]    w_len;

    assign w_left  = i_rd_row[AW-1:0];
    assign w_right = i_rd_row[2*AW-1:AW];
    assign w_rsym  = i_rd_row[RW-1:2*AW];
    assign w_leaf  = (w_left == '0) && (w_right == '0);

    // code bit under the walk; positions past the code field read as zero
    assign w_code_ext = {{(32 - CODE_W){1'b0}}, r_code};
    assign w_pos      = 5'(r_n - LW'(1));
    assign w_cbit     = w_code_ext[w_pos];

    // link selects: insert steps by code bit, decode by message bit
    assign w_link  = w_cbit ? w_right : w_left;
    assign w_child = r_bit ? w_right : w_left;

    // code length clamped to the deepest allowed walk
    assign w_len = ({1'b0, i_item.code_len} > 6'(MAX_LEN)) ? LW'(MAX_LEN)
                                                          : LW'(i_item.code_len);

    always_comb begin
        n_state   = r_state;
        n_used    = r_used;
        n_walk    = r_walk;
        n_cur     = r_cur;
        n_n       = r_n;
        n_sym     = r_sym;
        n_code    = r_code;
        n_bit     = r_bit;
        n_res     = r_res;
        o_rd_en   = 1'b0;
        o_rd_addr = r_cur;
        o_wr_en   = 1'b0;
        o_wr_addr = r_cur;
        o_wr_row  = i_rd_row;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_sym  = i_item.symbol;
                    n_code = i_item.code_bits;
                    n_bit  = i_item.bit_req;
                    if (i_item.func == FN_INSERT) begin
                        n_n     = w_len;
                        n_cur   = '0;
                        n_state = (w_len == '0) ? S_SYM_RD : S_INS_RD;
                    end else begin
                        n_cur   = r_walk;
                        n_state = S_DEC_RD;
                    end
                end
            end
            S_INS_RD: begin
                o_rd_en = 1'b1;
                n_state = S_INS_CHK;
            end
            // follow an existing child, link in a new one, or report a full table
            S_INS_CHK: begin
                if (w_link != '0) begin
                    n_cur   = w_link;
                    n_n     = r_n - LW'(1);
                    n_state = (r_n == LW'(1)) ? S_SYM_RD : S_INS_RD;
                end else if (r_used == CW'(NODES)) begin
                    n_res   = '{decoded_symbol: '0, status: ST_FULL};
                    n_state = S_OUT;
                end else begin
                    o_wr_en  = 1'b1;
                    o_wr_row = w_cbit ? {w_rsym, AW'(r_used), w_left}
                                      : {w_rsym, w_right, AW'(r_used)};
                    n_state  = S_INS_NEW;
                end
            end
            // fresh node row: no children, initial symbol
            S_INS_NEW: begin
                o_wr_en   = 1'b1;
                o_wr_addr = AW'(r_used);
                o_wr_row  = {INIT_SYMBOL, {(2 * AW){1'b0}}};
                n_used    = r_used + CW'(1);
                n_cur     = AW'(r_used);
                n_n       = r_n - LW'(1);
                n_state   = (r_n == LW'(1)) ? S_SYM_RD : S_INS_RD;
            end
            S_SYM_RD: begin
                o_rd_en = 1'b1;
                n_state = S_SYM_WR;
            end
            S_SYM_WR: begin
                o_wr_en  = 1'b1;
                o_wr_row = {r_sym, w_right, w_left};
                n_state  = S_IDLE;
            end
            S_DEC_RD: begin
                o_rd_en = 1'b1;
                n_state = S_DEC_CHK;
            end
            // step to the child if present, else test the current node
            S_DEC_CHK: begin
                if (w_child != '0) begin
                    n_cur   = w_child;
                    n_state = S_KID_RD;
                end else if (w_leaf) begin
                    n_walk  = '0;
                    n_res   = '{decoded_symbol: w_rsym, status: ST_OK};
                    n_state = S_OUT;
                end else begin
                    n_walk  = r_cur;
                    n_state = S_IDLE;
                end
            end
            S_KID_RD: begin
                o_rd_en = 1'b1;
                n_state = S_DEC_LEAF;
            end
            S_DEC_LEAF: begin
                if (w_leaf) begin
                    n_walk  = '0;
                    n_res   = '{decoded_symbol: w_rsym, status: ST_OK};
                    n_state = S_OUT;
                end else begin
                    n_walk  = r_cur;
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= CW'(1);
            r_walk  <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_walk  <= n_walk;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_n    <= n_n;
        r_sym  <= n_sym;
        r_code <= n_code;
        r_bit  <= n_bit;
        r_res  <= n_res;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_OUT);
    assign o_res       = r_res;
    assign o_used      = r_used;

endmodule

`default_nettype wire

// ----- hw/rtl/prefix_code_tree_decoder.sv -----
// Decode word: the node under the walk is read and checked; when the bit steps to a child,
// that child is read and checked too; a symbol that comes out enters the output register.
// Insert word: per code bit the node is read, and a missing child gets a link write and a
// fresh node row; then the symbol row is read and rewritten; the single-port node table sets this.
// Reset (synchronous, active low) empties the tree to the root alone and the walk to the root;
// no clearing pass: rows past the node count read as fresh nodes.
`default_nettype none

module prefix_code_tree_decoder
    import pctd_pkg::*;
#(
    parameter int NODES   = NODES_DEF,
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,  // symbol[7:0], code_bits[23:8], code_len[28:24],
                                         // bit_req[29], zero pad
    input  wire logic        i_s_tuser,  // func
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,  // decoded_symbol[7:0]
    output logic             o_m_tuser   // status
);

    localparam int AW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);
    localparam int RW = SYM_W + 2 * AW;

    t_item         w_item;
    t_res          w_res;
    logic          w_res_valid, w_res_ready;
    logic [CW-1:0] w_used;
    logic          w_rd_en, w_wr_en;
    logic [AW-1:0] w_rd_addr, w_wr_addr;
    logic [RW-1:0] w_rd_row, w_wr_row;
    logic          r_ovalid;
    t_res          r_ores;

    // unpack the input word
    assign w_item.func      = i_s_tuser;
    assign w_item.symbol    = i_s_tdata[7:0];
    assign w_item.code_bits = i_s_tdata[23:8];
    assign w_item.code_len  = i_s_tdata[28:24];
    assign w_item.bit_req   = i_s_tdata[29];

    pctd_seq #(
        .NODES   (NODES),
        .MAX_LEN (MAX_LEN)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_item      (w_item),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_used      (w_used),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_row    (w_rd_row),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_row    (w_wr_row)
    );

    pctd_mem #(
        .NODES (NODES)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_used    (w_used),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_row  (w_rd_row),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_row  (w_wr_row)
    );

    // output register: frees the sequencer while a word waits downstream
    assign w_res_ready = !r_ovalid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_ores <= w_res;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_ores.decoded_symbol;
    assign o_m_tuser  = r_ores.status;

endmodule

`default_nettype wire

// ----- tb/sv/tree_decode_checker.sv -----
`timescale 1ns / 100ps

module tree_decode_checker
    import pctd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [31:0] i_s_tdata,  // symbol[7:0], code_bits[23:8], code_len[28:24],
                                         // bit_req[29], zero pad
    input  wire logic        i_s_tuser,  // func
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [7:0]  i_m_tdata,  // decoded_symbol[7:0]
    input  wire logic        i_m_tuser,  // status
    output int               o_errors,
    output int               o_pending
);

    // shadow copy of the node table and walk state
    logic [8:0]       tree_left  [NODES_DEF];
    logic [8:0]       tree_right [NODES_DEF];
    logic [SYM_W-1:0] tree_sym   [NODES_DEF];
    logic [9:0]       tree_used;
    logic [8:0]       walk_node;

    t_res  symbols_due[$];
    t_item in_word;
    t_res  got_word;
    t_res  due_word;
    int    err_cnt;

    // apply one accepted word to the shadow tree, queue the symbol it emits (if any)
    task automatic tree_apply(input t_item w);
        logic [8:0] cur;
        logic [8:0] nxt;
        logic       b;
        logic       stop;
        int         n;
        t_res       r;
        cur  = '0;
        stop = 1'b0;
        if (w.func == FN_INSERT) begin
            n = (w.code_len > MAX_LEN_DEF) ? MAX_LEN_DEF : int'(w.code_len);
            while (n > 0 && !stop) begin
                b   = w.code_bits[n-1];
                nxt = b ? tree_right[cur] : tree_left[cur];
                if (nxt == '0) begin
                    if (tree_used >= NODES_DEF) begin
                        // pool exhausted: partial path stays, symbol untouched
                        r.decoded_symbol = '0;
                        r.status         = ST_FULL;
                        symbols_due.push_back(r);
                        stop = 1'b1;
                    end else begin
                        nxt = tree_used[8:0];
                        if (b) begin
                            tree_right[cur] = nxt;
                        end else begin
                            tree_left[cur] = nxt;
                        end
                        tree_used = tree_used + 10'd1;
                    end
                end
                cur = nxt;
                n   = n - 1;
            end
            if (!stop) begin
                tree_sym[cur] = w.symbol;
            end
        end else begin
            // missing child keeps the walk where it is
            cur = walk_node;
            if (!w.bit_req) begin
                if (tree_left[cur] != '0) begin
                    cur = tree_left[cur];
                end
            end else begin
                if (tree_right[cur] != '0) begin
                    cur = tree_right[cur];
                end
            end
            if (tree_left[cur] == '0 && tree_right[cur] == '0) begin
                r.decoded_symbol = tree_sym[cur];
                r.status         = ST_OK;
                symbols_due.push_back(r);
                walk_node = '0;
            end else begin
                walk_node = cur;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NODES_DEF; k++) begin
                tree_left[k]  = '0;
                tree_right[k] = '0;
                tree_sym[k]   = INIT_SYMBOL;
            end
            tree_used = 10'd1;
            walk_node = '0;
            symbols_due.delete();
            err_cnt = 0;
        end else begin
            // input word accepted
            if (i_s_tvalid && i_s_tready) begin
                in_word.func      = i_s_tuser;
                in_word.symbol    = i_s_tdata[7:0];
                in_word.code_bits = i_s_tdata[23:8];
                in_word.code_len  = i_s_tdata[28:24];
                in_word.bit_req   = i_s_tdata[29];
                tree_apply(in_word);
            end
            // result word accepted
            if (i_m_tvalid && i_m_tready) begin
                got_word.decoded_symbol = i_m_tdata;
                got_word.status         = i_m_tuser;
                if (symbols_due.size() == 0) begin
                    $error("unexpected result word: decoded_symbol %0d, status %0d",
                           got_word.decoded_symbol, got_word.status);
                    err_cnt++;
                end else begin
                    due_word = symbols_due.pop_front();
                    if (got_word.decoded_symbol !== due_word.decoded_symbol) begin
                        $error("decoded_symbol mismatch: expected %0d, actual %0d",
                               due_word.decoded_symbol, got_word.decoded_symbol);
                        err_cnt++;
                    end
                    if (got_word.status !== due_word.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               due_word.status, got_word.status);
                        err_cnt++;
                    end
                end
            end
        end
        o_errors  <= err_cnt;
        o_pending <= symbols_due.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import pctd_pkg::*;

    localparam int  TIMEOUT_NS = 10_000_000;
    localparam int  TAIL_WAIT  = 100;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;  // symbol[7:0], code_bits[23:8], code_len[28:24], bit_req[29], pad
    logic        s_tuser;  // func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;  // decoded_symbol[7:0]
    logic        m_tuser;  // status
    int          chk_errors;
    int          chk_pending;

    int          burst_left;
    logic        steady;
    int          words_sent;
    logic [20:0] known_codes[$];  // {code_len, code_bits} of past inserts
    int          rx_mode = 0;
    int          rx_left = 0;

    prefix_code_tree_decoder DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    tree_decode_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .o_errors   (chk_errors),
        .o_pending  (chk_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: ready pattern changes mode every so often
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 2);
            rx_left <= $urandom_range(16, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    function automatic t_item insert_word(input logic [7:0] sym, input logic [15:0] code,
                                          input logic [4:0] len);
        t_item w;
        w.func      = FN_INSERT;
        w.symbol    = sym;
        w.code_bits = code;
        w.code_len  = len;
        w.bit_req   = 1'($urandom_range(0, 1));
        return w;
    endfunction

    // don't-care fields of a decode word carry noise
    function automatic t_item decode_word(input logic b);
        t_item w;
        w.func      = FN_DECODE;
        w.symbol    = 8'($urandom_range(0, 255));
        w.code_bits = 16'($urandom_range(0, 65535));
        w.code_len  = 5'($urandom_range(0, 31));
        w.bit_req   = b;
        return w;
    endfunction

    // sender: bursts of words separated by random gaps
    task automatic send_word(input t_item w);
        int gap;
        if (burst_left == 0) begin
            gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, w.bit_req, w.code_len, w.code_bits, w.symbol};
        s_tuser  <= w.func;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        words_sent++;
        if (w.func == FN_INSERT) begin
            known_codes.push_back({w.code_len, w.code_bits});
            if (known_codes.size() > 64) begin
                void'(known_codes.pop_front());
            end
        end
    endtask

    // hold the sender until every due symbol has come back
    task automatic wait_results();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [4:0] pick_len(input logic deep);
        int r;
        r = $urandom_range(0, 15);
        if (deep) begin
            return 5'($urandom_range(12, 31));
        end else if (r == 0) begin
            return 5'd0;
        end else if (r == 1) begin
            return 5'($urandom_range(17, 31));
        end else if (r == 2) begin
            return 5'($urandom_range(8, 16));
        end
        return 5'($urandom_range(1, 7));
    endfunction

    // replay the bits of a previously inserted code as decode words
    task automatic send_codeword();
        logic [20:0] entry;
        int          n;
        if (known_codes.size() == 0) begin
            send_word(decode_word(1'($urandom_range(0, 1))));
        end else begin
            entry = known_codes[$urandom_range(0, known_codes.size() - 1)];
            n = (entry[20:16] > MAX_LEN_DEF) ? MAX_LEN_DEF : int'(entry[20:16]);
            if (n == 0) begin
                send_word(decode_word(1'($urandom_range(0, 1))));
            end
            for (int i = n - 1; i >= 0; i--) begin
                send_word(decode_word(entry[i]));
            end
        end
    endtask

    // one random step: an insert, a code word replay, or a single noise bit
    task automatic random_step(input int insert_odds, input logic deep);
        if ($urandom_range(0, insert_odds - 1) == 0) begin
            send_word(insert_word(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                                  pick_len(deep)));
        end else if ($urandom_range(0, 2) == 0) begin
            send_codeword();
        end else begin
            send_word(decode_word(1'($urandom_range(0, 1))));
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= FN_INSERT;
        burst_left = 0;
        steady     = 1'b0;
        words_sent = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty tree, root symbol, missing child, walk interrupted by insert
        send_word(decode_word(1'b0));
        send_word(decode_word(1'b1));
        send_word(insert_word(8'hFF, 16'hFFFF, 5'd0));
        send_word(decode_word(1'b1));
        send_word(insert_word(8'h00, 16'h0000, 5'd0));
        send_word(decode_word(1'b0));
        send_word(insert_word(8'h41, 16'h0000, 5'd1));
        send_word(decode_word(1'b1));
        send_word(decode_word(1'b0));
        send_word(insert_word(8'h80, 16'h0003, 5'd2));
        send_word(decode_word(1'b1));
        send_word(insert_word(8'h7F, 16'h0002, 5'd2));
        send_word(decode_word(1'b0));
        send_word(decode_word(1'b1));
        send_word(decode_word(1'b1));
        send_word(insert_word(8'hA5, 16'hFFFF, 5'd31));
        send_word(insert_word(8'h5A, 16'h0000, 5'd16));
        send_word(insert_word(8'hC3, 16'h0001, 5'd20));
        send_word(decode_word(1'b0));
        send_word(decode_word(1'b1));
        send_word(insert_word(8'h3C, 16'hFFFF, 5'd1));
        wait_results();

        // mixed traffic on a growing tree
        while (words_sent < 1120) random_step(8, 1'b0);
        wait_results();

        // deep inserts until the node pool runs out, no sender gaps
        steady = 1'b1;
        while (words_sent < 1250) random_step(2, 1'b1);
        steady = 1'b0;
        wait_results();

        // full tree: mostly decoding, inserts overwrite or fail
        while (words_sent < 1720) random_step(10, 1'b0);

        wait_results();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
